// ===== design/fif_pkg.sv =====
`timescale 1ns / 1ps

package fif_pkg;

   // Default number of fraction bits; 1.0 is 2**FRACTION_BITS.
   localparam int FRACTION_BITS_DEF = 16;

   // Width of the register bus data.
   localparam int CSR_DATA_W = 32;
   // Byte address bits: five registers at 4*i.
   localparam int CSR_ADDR_W = 5;

   // Register map, by word index.
   typedef enum logic [2:0] {
      REG_INTEGRAL_KIND = 3'd0,
      REG_SOURCE_MODE   = 3'd1,
      REG_WEIGHT_FIRST  = 3'd2,
      REG_WEIGHT_SECOND = 3'd3,
      REG_WEIGHT_THIRD  = 3'd4
   } csr_index_type;

   // integral_kind codes.
   localparam logic KIND_CHOQUET = 1'b0;
   localparam logic KIND_SUGENO  = 1'b1;

   // source_mode codes.
   localparam logic SRC_TEXTURE_COLOUR = 1'b0;
   localparam logic SRC_COLOUR_ONLY    = 1'b1;

endpackage

// ===== design/fuzzy_integral_fusion.sv =====
`timescale 1ns / 1ps

// Fuzzy integral fusion of three similarity degrees, one pixel per word.
// Each request word carries four degrees in unsigned fixed point with
// FRACTION_BITS fraction bits (1.0 = 2**FRACTION_BITS); source_mode picks
// texture plus colour a/b (0) or colour a/b/c (1). Degrees and weights above
// 1.0 are clamped to 1.0, the three degrees are sorted ascending (ties keep
// source order), and either the Choquet integral (rounded half up) or the
// Sugeno integral is returned, saturated to 0..1.0. The datapath is a
// four-stage pipeline: clamp/select, sort, multiply, sum/round. The response
// word is held in the register of each stage in turn, and rsp_valid is the
// valid flag of the last stage. While the response side is not stalling, a
// new word can be taken every cycle; throughput is one word per clock, set by
// the three parallel multipliers of the multiply stage. Each stage holds its
// word while the stage after it is full and stalled, and empty stages collapse,
// so a stalled response leaves room for up to three more words in flight.
// Registers (APB-style, 4-byte stride, pready always high): 0 integral_kind,
// 1 source_mode, 2..4 weight_first/second/third. Write them only while the
// pipeline is empty; writes to other addresses are dropped.

module fuzzy_integral_fusion #(
   parameter int FRACTION_BITS = fif_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [FRACTION_BITS:0]           req_texture_degree,
   input  logic [FRACTION_BITS:0]           req_colour_degree_a,
   input  logic [FRACTION_BITS:0]           req_colour_degree_b,
   input  logic [FRACTION_BITS:0]           req_colour_degree_c,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [FRACTION_BITS:0]           rsp_fused_value,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fif_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fif_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fif_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import fif_pkg::*;

   // Value width: one integer bit plus the fraction.
   localparam int N  = FRACTION_BITS + 1;
   // Signed product and sum width.
   localparam int PW = 2 * N + 3;

   localparam logic [N-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [N-1:0] HALF = ONE >> 1;

   localparam longint unsigned ONE_INT = 64'd1 << FRACTION_BITS;
   localparam logic [N-1:0] WEIGHT_LO_RST = N'(ONE_INT / 3);
   localparam logic [N-1:0] WEIGHT_HI_RST = N'(ONE_INT - 2 * (ONE_INT / 3));

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic          kind_ff;
   logic          mode_ff;
   logic [N-1:0]  weight_first_ff;
   logic [N-1:0]  weight_second_ff;
   logic [N-1:0]  weight_third_ff;

   csr_index_type csr_index;
   logic          csr_write;

   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff          <= KIND_CHOQUET;
         mode_ff          <= SRC_TEXTURE_COLOUR;
         weight_first_ff  <= WEIGHT_LO_RST;
         weight_second_ff <= WEIGHT_LO_RST;
         weight_third_ff  <= WEIGHT_HI_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_INTEGRAL_KIND: kind_ff          <= csr_pwdata[0];
            REG_SOURCE_MODE:   mode_ff          <= csr_pwdata[0];
            REG_WEIGHT_FIRST:  weight_first_ff  <= csr_pwdata[N-1:0];
            REG_WEIGHT_SECOND: weight_second_ff <= csr_pwdata[N-1:0];
            REG_WEIGHT_THIRD:  weight_third_ff  <= csr_pwdata[N-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_INTEGRAL_KIND: csr_prdata = CSR_DATA_W'(kind_ff);
         REG_SOURCE_MODE:   csr_prdata = CSR_DATA_W'(mode_ff);
         REG_WEIGHT_FIRST:  csr_prdata = CSR_DATA_W'(weight_first_ff);
         REG_WEIGHT_SECOND: csr_prdata = CSR_DATA_W'(weight_second_ff);
         REG_WEIGHT_THIRD:  csr_prdata = CSR_DATA_W'(weight_third_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Stage advance: a stage loads when it is empty or its word moves on.
   // ------------------------------------------------------------------
   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic adv_a, adv_b, adv_c, adv_d;

   assign adv_d     = !vd_ff || rsp_ready;
   assign adv_c     = !vc_ff || adv_d;
   assign adv_b     = !vb_ff || adv_c;
   assign adv_a     = !va_ff || adv_b;
   assign req_ready = adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (adv_a) va_ff <= req_valid;
         if (adv_b) vb_ff <= va_ff;
         if (adv_c) vc_ff <= vb_ff;
         if (adv_d) vd_ff <= vc_ff;
      end
   end

   function automatic logic [N-1:0] clamp_one(input logic [N-1:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

   // ------------------------------------------------------------------
   // Stage A: select sources, clamp degrees and weights
   // ------------------------------------------------------------------
   logic [N-1:0] va_deg_ff [3];
   logic [N-1:0] va_wgt_ff [3];
   logic         va_kind_ff;

   always_ff @(posedge clock) begin
      if (adv_a) begin
         if (mode_ff == SRC_COLOUR_ONLY) begin
            va_deg_ff[0] <= clamp_one(req_colour_degree_a);
            va_deg_ff[1] <= clamp_one(req_colour_degree_b);
            va_deg_ff[2] <= clamp_one(req_colour_degree_c);
         end else begin
            va_deg_ff[0] <= clamp_one(req_texture_degree);
            va_deg_ff[1] <= clamp_one(req_colour_degree_a);
            va_deg_ff[2] <= clamp_one(req_colour_degree_b);
         end
         va_wgt_ff[0] <= clamp_one(weight_first_ff);
         va_wgt_ff[1] <= clamp_one(weight_second_ff);
         va_wgt_ff[2] <= clamp_one(weight_third_ff);
         va_kind_ff   <= kind_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: stable ascending sort by rank
   // ------------------------------------------------------------------
   logic [1:0]   rank [3];
   logic [N-1:0] xs_in [3];
   logic [N-1:0] gs_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rank[i] = 2'd0;
         for (int j = 0; j < 3; j++) begin
            if (va_deg_ff[j] < va_deg_ff[i] || (va_deg_ff[j] == va_deg_ff[i] && j < i))
               rank[i] = rank[i] + 2'd1;
         end
      end
      for (int k = 0; k < 3; k++) begin
         xs_in[k] = '0;
         gs_in[k] = '0;
         for (int i = 0; i < 3; i++) begin
            if (rank[i] == 2'(k)) begin
               xs_in[k] = va_deg_ff[i];
               gs_in[k] = va_wgt_ff[i];
            end
         end
      end
   end

   logic [N-1:0] vb_x1_ff, vb_x2_ff, vb_x3_ff, vb_g2_ff, vb_g3_ff;
   logic         vb_kind_ff;

   always_ff @(posedge clock) begin
      if (adv_b) begin
         vb_x1_ff   <= xs_in[0];
         vb_x2_ff   <= xs_in[1];
         vb_x3_ff   <= xs_in[2];
         vb_g2_ff   <= gs_in[1];
         vb_g3_ff   <= gs_in[2];
         vb_kind_ff <= va_kind_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage C: Choquet products, Sugeno min/max
   // ------------------------------------------------------------------
   logic [N:0]          gsum;
   logic signed [N+1:0] wlow;
   logic signed [PW-1:0] p1_in, p2_in, p3_in;
   logic [N-1:0]        sug_b, sug_c, sug_in;

   always_comb begin
      gsum  = {1'b0, vb_g2_ff} + {1'b0, vb_g3_ff};
      // Weight of the smallest degree: 1 - g2 - g3, may go negative.
      wlow  = $signed({2'b00, ONE}) - $signed({1'b0, gsum});
      // Widen both operands to the full product width before multiplying.
      p1_in = PW'($signed({1'b0, vb_x1_ff})) * PW'(wlow);
      p2_in = $signed(PW'(vb_x2_ff)) * $signed(PW'(vb_g2_ff));
      p3_in = $signed(PW'(vb_x3_ff)) * $signed(PW'(vb_g3_ff));
      sug_b = ({1'b0, vb_x2_ff} < gsum) ? vb_x2_ff : gsum[N-1:0];
      sug_c = (vb_x3_ff < vb_g3_ff) ? vb_x3_ff : vb_g3_ff;
      sug_in = vb_x1_ff;
      if (sug_b > sug_in) sug_in = sug_b;
      if (sug_c > sug_in) sug_in = sug_c;
   end

   logic signed [PW-1:0] vc_p1_ff, vc_p2_ff, vc_p3_ff;
   logic [N-1:0]         vc_sug_ff;
   logic                 vc_kind_ff;

   always_ff @(posedge clock) begin
      if (adv_c) begin
         vc_p1_ff   <= p1_in;
         vc_p2_ff   <= p2_in;
         vc_p3_ff   <= p3_in;
         vc_sug_ff  <= sug_in;
         vc_kind_ff <= vb_kind_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage D: sum, round half up, saturate, pick the integral
   // ------------------------------------------------------------------
   logic signed [PW-1:0] sum;
   logic [PW-1:0]        rounded;
   logic [PW-1:0]        quot;
   logic [N-1:0]         fused_in;

   always_comb begin
      sum     = vc_p1_ff + vc_p2_ff + vc_p3_ff;
      rounded = unsigned'(sum) + PW'(HALF);
      quot    = rounded >> FRACTION_BITS;
      if (vc_kind_ff == KIND_SUGENO) begin
         fused_in = clamp_one(vc_sug_ff);
      end else if (sum <= 0) begin
         fused_in = '0;
      end else if (quot > PW'(ONE)) begin
         fused_in = ONE;
      end else begin
         fused_in = quot[N-1:0];
      end
   end

   logic [N-1:0] vd_fused_ff;

   always_ff @(posedge clock) begin
      if (adv_d) vd_fused_ff <= fused_in;
   end

   assign rsp_valid       = vd_ff;
   assign rsp_fused_value = vd_fused_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      va_ff |-> (va_deg_ff[0] <= ONE && va_deg_ff[1] <= ONE && va_deg_ff[2] <= ONE))
      else $error("stage A holds an unclamped degree");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> (vb_x1_ff <= vb_x2_ff && vb_x2_ff <= vb_x3_ff))
      else $error("sort stage out of order");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fused_value <= ONE)
      else $error("fused value above 1.0");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (vc_ff && !adv_d) |=> (vc_ff && $stable(vc_p1_ff) && $stable(vc_sug_ff)))
      else $error("multiply stage lost its word during a stall");

endmodule

// ===== bench/fif_checker.sv =====
`timescale 1ns / 1ps

module fif_checker #(
   parameter int FRAC = fif_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [FRAC:0]                    req_texture_degree,
   input  logic [FRAC:0]                    req_colour_degree_a,
   input  logic [FRAC:0]                    req_colour_degree_b,
   input  logic [FRAC:0]                    req_colour_degree_c,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [FRAC:0]                    rsp_fused_value,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fif_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fif_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [fif_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                             csr_pready,
   output int                               mismatch_count,
   output int                               pending_count
);
   import fif_pkg::*;

   localparam longint UNIT = longint'(1) << FRAC;
   localparam int     DW   = FRAC + 1;
   localparam int     REPORT_LIMIT = 10;

   // Reset weights: thirds of 1.0, the last one taking the remainder.
   localparam logic [FRAC:0] WEIGHT_LO_RST = DW'(UNIT / 3);
   localparam logic [FRAC:0] WEIGHT_HI_RST = DW'(UNIT - 2 * (UNIT / 3));

   // Shadow copy of the register file.
   logic          integral_kind;
   logic          source_mode;
   logic [FRAC:0] weight_first;
   logic [FRAC:0] weight_second;
   logic [FRAC:0] weight_third;

   logic [FRAC:0] expected_fused[$];
   logic [FRAC:0] oldest_fused;
   logic [CSR_DATA_W-1:0] register_value;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic longint clamp_unit(input longint v);
      return (v > UNIT) ? UNIT : v;
   endfunction

   // Fuse one pixel under the current shadow registers.
   function automatic logic [FRAC:0] fuse_pixel(input logic [FRAC:0] t, a, b, c);
      longint x[3];
      longint g[3];
      longint swap;
      longint acc;
      int     i;
      int     j;
      if (source_mode == SRC_TEXTURE_COLOUR) begin
         x[0] = clamp_unit(t);
         x[1] = clamp_unit(a);
         x[2] = clamp_unit(b);
      end else begin
         x[0] = clamp_unit(a);
         x[1] = clamp_unit(b);
         x[2] = clamp_unit(c);
      end
      g[0] = clamp_unit(weight_first);
      g[1] = clamp_unit(weight_second);
      g[2] = clamp_unit(weight_third);
      // Insertion sort moves only on strict greater, so ties keep source order.
      for (i = 1; i < 3; i++) begin
         j = i;
         while (j > 0 && x[j-1] > x[j]) begin
            swap = x[j]; x[j] = x[j-1]; x[j-1] = swap;
            swap = g[j]; g[j] = g[j-1]; g[j-1] = swap;
            j--;
         end
      end
      if (integral_kind == KIND_CHOQUET) begin
         acc = x[0] * (UNIT - g[1] - g[2]) + x[1] * g[1] + x[2] * g[2];
         if (acc <= 0)
            acc = 0;
         else
            acc = clamp_unit((acc + (UNIT >> 1)) >>> FRAC);
      end else begin
         acc = x[0];
         if (((x[1] < g[1] + g[2]) ? x[1] : g[1] + g[2]) > acc)
            acc = (x[1] < g[1] + g[2]) ? x[1] : g[1] + g[2];
         if (((x[2] < g[2]) ? x[2] : g[2]) > acc)
            acc = (x[2] < g[2]) ? x[2] : g[2];
         acc = clamp_unit(acc);
      end
      return acc[FRAC:0];
   endfunction

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         integral_kind = KIND_CHOQUET;
         source_mode   = SRC_TEXTURE_COLOUR;
         weight_first  = WEIGHT_LO_RST;
         weight_second = WEIGHT_LO_RST;
         weight_third  = WEIGHT_HI_RST;
         expected_fused.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[CSR_ADDR_W-1:2])
                  REG_INTEGRAL_KIND: integral_kind = csr_pwdata[0];
                  REG_SOURCE_MODE:   source_mode   = csr_pwdata[0];
                  REG_WEIGHT_FIRST:  weight_first  = csr_pwdata[FRAC:0];
                  REG_WEIGHT_SECOND: weight_second = csr_pwdata[FRAC:0];
                  REG_WEIGHT_THIRD:  weight_third  = csr_pwdata[FRAC:0];
                  default: ;
               endcase
            end else begin
               register_value = '0;
               case (csr_paddr[CSR_ADDR_W-1:2])
                  REG_INTEGRAL_KIND: register_value[0]      = integral_kind;
                  REG_SOURCE_MODE:   register_value[0]      = source_mode;
                  REG_WEIGHT_FIRST:  register_value[FRAC:0] = weight_first;
                  REG_WEIGHT_SECOND: register_value[FRAC:0] = weight_second;
                  REG_WEIGHT_THIRD:  register_value[FRAC:0] = weight_third;
                  default: ;
               endcase
               if (csr_prdata !== register_value)
                  flag_mismatch("register read", register_value, csr_prdata);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_fused.size() == 0) begin
               flag_mismatch("unexpected word, fused_value", -1, rsp_fused_value);
            end else begin
               oldest_fused = expected_fused.pop_front();
               if (rsp_fused_value !== oldest_fused)
                  flag_mismatch("fused_value", oldest_fused, rsp_fused_value);
            end
         end
         if (req_valid && req_ready)
            expected_fused.push_back(fuse_pixel(req_texture_degree, req_colour_degree_a,
                                                req_colour_degree_b, req_colour_degree_c));
      end
      pending_count <= expected_fused.size();
   end

endmodule

// ===== bench/tb_fuzzy_integral_fusion.sv =====
`timescale 1ns / 1ps

module tb_fuzzy_integral_fusion;
   import fif_pkg::*;

   localparam int            FRAC     = FRACTION_BITS_DEF;
   localparam int            DW       = FRAC + 1;
   localparam logic [FRAC:0] UNIT     = DW'(1) << FRAC;
   localparam logic [FRAC:0] ALL_ONES = '1;

   // Indexes past the last register, up to what paddr can reach.
   localparam int FIRST_UNMAPPED = int'(REG_WEIGHT_THIRD) + 1;
   localparam int LAST_INDEX     = (1 << (CSR_ADDR_W - 2)) - 1;

   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 10;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [FRAC:0]           req_texture_degree;
   logic [FRAC:0]           req_colour_degree_a;
   logic [FRAC:0]           req_colour_degree_b;
   logic [FRAC:0]           req_colour_degree_c;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [FRAC:0]           rsp_fused_value;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int mismatch_count;
   int pending_count;
   int quiet_cycles;

   // Knobs for the request side and the response side.
   bit req_fast;
   bit rsp_fast;
   bit rsp_hold_request;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fuzzy_integral_fusion #(.FRACTION_BITS(FRAC)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_texture_degree  (req_texture_degree),
      .req_colour_degree_a (req_colour_degree_a),
      .req_colour_degree_b (req_colour_degree_b),
      .req_colour_degree_c (req_colour_degree_c),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_fused_value     (rsp_fused_value),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   fif_checker #(.FRAC(FRAC)) scoreboard (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_texture_degree  (req_texture_degree),
      .req_colour_degree_a (req_colour_degree_a),
      .req_colour_degree_b (req_colour_degree_b),
      .req_colour_degree_c (req_colour_degree_c),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_fused_value     (rsp_fused_value),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count)
   );

   // Watchdog: count cycles in which no word moves on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: draw a stall per word; a hold request turns that stall into
   // one long stretch so the pipeline fills and backs up into req_ready.
   initial begin : rsp_side
      int gap;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            gap = RSP_HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end else begin
            gap = rsp_fast ? 0 : $urandom_range(0, 9);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Offer one pixel after a random gap and hold it until it is taken.
   task automatic send_pixel(input logic [FRAC:0] t, a, b, c);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_texture_degree  <= t;
      req_colour_degree_a <= a;
      req_colour_degree_b <= b;
      req_colour_degree_c <= c;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Drop valid and wait until every pixel in flight has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Setup and access phases; psel stays high so back-to-back transfers chain.
   task automatic csr_access(input bit write, input int index, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(index << 2);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Read every mapped register back, then release the bus.
   task automatic read_back();
      int idx;
      for (idx = int'(REG_INTEGRAL_KIND); idx <= int'(REG_WEIGHT_THIRD); idx++)
         csr_access(1'b0, idx, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Put junk above the register's width at random; the block must mask it.
   function automatic logic [31:0] pad_word(input logic [31:0] value, input int used_bits);
      logic [31:0] junk;
      junk = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
      return (junk << used_bits) | value;
   endfunction

   task automatic program_block(input logic kind, input logic mode,
                                input logic [FRAC:0] wf, ws, wt, input bit poke_unmapped);
      int idx;
      // Writes past the last register must leave everything untouched.
      if (poke_unmapped)
         for (idx = FIRST_UNMAPPED; idx <= LAST_INDEX; idx++)
            csr_access(1'b1, idx, $urandom);
      csr_access(1'b1, REG_INTEGRAL_KIND, pad_word(kind, 1));
      csr_access(1'b1, REG_SOURCE_MODE,   pad_word(mode, 1));
      csr_access(1'b1, REG_WEIGHT_FIRST,  pad_word(wf, DW));
      csr_access(1'b1, REG_WEIGHT_SECOND, pad_word(ws, DW));
      csr_access(1'b1, REG_WEIGHT_THIRD,  pad_word(wt, DW));
      read_back();
   endtask

   // Hand-picked corners: zeros, all at 1.0, all above 1.0, distinct orders,
   // ties, and a large degree on the input the mode does not select.
   task automatic run_corners();
      send_pixel('0, '0, '0, '0);
      send_pixel(UNIT, UNIT, UNIT, UNIT);
      send_pixel(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_pixel(UNIT, '0, UNIT >> 1, ALL_ONES);
      send_pixel(DW'(5), DW'(5), DW'(5), DW'(5));
      send_pixel('0, UNIT, UNIT, '0);
      send_pixel(DW'(100), DW'(200), DW'(100), ALL_ONES);
      send_pixel(ALL_ONES, DW'(3), '0, DW'(7));
   endtask

   function automatic logic [FRAC:0] pick_degree();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return UNIT;
         2:       return DW'($urandom_range(int'(UNIT) + 1, int'(ALL_ONES)));
         3:       return DW'($urandom);
         4:       return DW'($urandom_range(0, 3));
         default: return DW'($urandom_range(0, int'(UNIT)));
      endcase
   endfunction

   function automatic logic [FRAC:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return UNIT;
         2:       return DW'($urandom_range(int'(UNIT) + 1, int'(ALL_ONES)));
         3:       return DW'($urandom);
         default: return DW'($urandom_range(0, int'(UNIT)));
      endcase
   endfunction

   initial begin : stimulus
      int            phase;
      int            n;
      int            share;
      logic [FRAC:0] wf, ws, wt;
      logic [FRAC:0] t, a, b, c;

      // Drive every input to a known value before the first edge.
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_texture_degree  = '0;
      req_colour_degree_a = '0;
      req_colour_degree_b = '0;
      req_colour_degree_c = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_fast            = 1'b0;
      rsp_fast            = 1'b0;
      rsp_hold_request    = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners under the reset settings, then Sugeno on colour only with extreme
      // weights, then Choquet with weights summing past 1.0 (a negative weight on
      // the smallest degree and sums above 1.0).
      read_back();
      run_corners();
      settle();
      program_block(KIND_SUGENO, SRC_COLOUR_ONLY, UNIT, '0, ALL_ONES, 1'b1);
      run_corners();
      settle();
      program_block(KIND_CHOQUET, SRC_COLOUR_ONLY, ALL_ONES, ALL_ONES, UNIT, 1'b0);
      run_corners();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         if (phase == 4) begin
            wf = '0; ws = '0; wt = '0;
         end else if (phase == 5) begin
            wf = UNIT; ws = UNIT; wt = UNIT;
         end else if (phase == 6) begin
            wf = ALL_ONES; ws = ALL_ONES; wt = ALL_ONES;
         end else if (phase % 3 == 2) begin
            // Proper measure: the weights add up to exactly 1.0.
            share = $urandom_range(0, int'(UNIT));
            wf = DW'(share);
            share = $urandom_range(0, int'(UNIT) - share);
            ws = DW'(share);
            wt = UNIT - wf - ws;
         end else begin
            wf = pick_weight(); ws = pick_weight(); wt = pick_weight();
         end
         program_block((phase % 2 == 1) ? KIND_SUGENO : KIND_CHOQUET,
                       ((phase / 2) % 2 == 1) ? SRC_COLOUR_ONLY : SRC_TEXTURE_COLOUR,
                       wf, ws, wt, phase % 4 == 3);

         req_fast = (phase == 3) || ($urandom_range(0, 3) == 0);
         rsp_fast = ($urandom_range(0, 3) == 0);
         // Keep offering back to back while the response side holds off.
         if (phase == 3)
            rsp_hold_request = 1'b1;

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Pause the sender once mid-phase until everything has drained.
            if (phase == 5 && n == ITEMS_PER_PHASE / 2)
               settle();
            t = pick_degree();
            a = pick_degree();
            b = pick_degree();
            c = pick_degree();
            // Force ties now and then to exercise the stable ordering.
            if ($urandom_range(0, 4) == 0) b = a;
            if ($urandom_range(0, 5) == 0) c = b;
            if ($urandom_range(0, 5) == 0) t = b;
            send_pixel(t, a, b, c);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/fif_pkg.sv
design/fuzzy_integral_fusion.sv
bench/fif_checker.sv
bench/tb_fuzzy_integral_fusion.sv
